### rtl/core/crc32_framed_envelope_check_assert.svh
// Assertion macros for the envelope checker RTL.
// Depends on nothing; included by the one RTL file that has assertions.
`ifndef CRC32_FRAMED_ENVELOPE_CHECK_ASSERT_SVH
`define CRC32_FRAMED_ENVELOPE_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent in this cycle implies consequent in the same cycle.
`define CFE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("envelope checker assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define CFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("envelope checker assertion failed");

`else

`define CFE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/cfe_pkg.sv
// Shared types, constants and the CRC-32 byte update of the envelope checker.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package cfe_pkg;

  // Header layout and CRC parameters.
  localparam logic [32:0] HDR_BYTES     = 33'd20;
  localparam logic [32:0] OFF_VERSION   = 33'd4;
  localparam logic [32:0] OFF_ALGO      = 33'd8;
  localparam logic [32:0] OFF_CRC_FIELD = 33'd16;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  // Reset values of the configuration registers.
  localparam logic [31:0] MAGIC_RESET   = 32'h4653_4749;
  localparam logic [31:0] VERSION_RESET = 32'd1;
  localparam logic [31:0] ALGO_RESET    = 32'd1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALGO    = 2'd2;

  // Header word numbers (byte position divided by four).
  localparam logic [2:0] FLD_MAGIC   = 3'd0;
  localparam logic [2:0] FLD_VERSION = 3'd1;
  localparam logic [2:0] FLD_ALGO    = 3'd2;
  localparam logic [2:0] FLD_LENGTH  = 3'd3;
  localparam logic [2:0] FLD_CRC     = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_ALGO    = 3'd4;
  localparam logic [2:0] ST_SHORT   = 3'd5;
  localparam logic [2:0] ST_TRAIL   = 3'd6;
  localparam logic [2:0] ST_CRC     = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_file;
  } cfe_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [32:0] error_offset;
    logic [31:0] expected_value;
    logic [31:0] actual_value;
    logic [31:0] payload_length;
  } cfe_out_t;

  // Reflected CRC-32 update by one byte, eight bit steps unrolled.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cfe_out_stage.sv
// Result holding register of the envelope checker with valid/stall output.
// Depends on cfe_pkg for the result transaction type.
`default_nettype none

module cfe_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire cfe_pkg::cfe_out_t load_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cfe_pkg::cfe_out_t     out_data
);
  import cfe_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  cfe_out_t data_r;

  // A held result stays until taken or replaced by a new load.
  always_comb begin
    valid_nxt = load | (valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register carries no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/crc32_framed_envelope_check.sv
// Envelope checker for a 20-byte header plus payload, protected by CRC-32.
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one file item per
//   transaction: a byte with has_byte set, an end marker with end_of_file set,
//   or both. Header words are checked as each one completes and the payload
//   runs through a byte-wide CRC-32. The first error is kept; later bytes of
//   the same file are ignored.
//   On the transaction with end_of_file the block places one result on the
//   output channel (out_valid, out_stall, out_data) in the next cycle and
//   starts over for the next file. Other transactions give no result.
//   Throughput is one item per clock while in_stall is low: the whole
//   per-byte update (CRC byte step, header compare, length bound) is
//   combinational logic into the state registers, and the result register
//   is loaded in the same cycle.
//   While a result is held under out_stall, in_stall is raised; the held
//   result does not change until it is taken.
//   Reset (rst_n low, synchronous) clears the file state and the output valid,
//   and returns the configuration registers to their defaults. The user writes
//   configuration (cfg_we, cfg_index, cfg_wdata) between files; not enforced.
// Depends on cfe_pkg, cfe_out_stage and the assertion macro header.
`default_nettype none

`include "crc32_framed_envelope_check_assert.svh"

module crc32_framed_envelope_check (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire cfe_pkg::cfe_in_t                  in_data,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output cfe_pkg::cfe_out_t                      out_data,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [cfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_wdata
);
  import cfe_pkg::*;

  // Configuration registers.
  logic [31:0] magic_r;
  logic [31:0] version_r;
  logic [31:0] algo_r;

  // File state.
  logic [32:0] pos_r,      pos_nxt;
  logic [31:0] shift_r,    shift_nxt;
  logic [31:0] len_r,      len_nxt;
  logic [32:0] pay_end_r,  pay_end_nxt;
  logic [31:0] scrc_r,     scrc_nxt;
  logic [31:0] crc_r,      crc_nxt;
  logic [2:0]  err_code_r, err_code_nxt;
  logic [32:0] err_off_r,  err_off_nxt;
  logic [31:0] err_exp_r,  err_exp_nxt;
  logic [31:0] err_act_r,  err_act_nxt;

  logic        in_acc;
  logic        eof_acc;
  logic        take;
  logic [31:0] crc_final;
  cfe_out_t    res;

  assign in_acc  = in_valid & ~in_stall;
  assign eof_acc = in_acc & in_data.end_of_file;
  assign take    = in_acc & in_data.has_byte & (err_code_r == ST_OK);

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RESET;
      version_r <= VERSION_RESET;
      algo_r    <= ALGO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:   magic_r   <= cfg_wdata;
        CFG_VERSION: version_r <= cfg_wdata;
        CFG_ALGO:    algo_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-byte update, end-of-file verdict and restart for the next file.
  always_comb begin
    pos_nxt      = pos_r;
    shift_nxt    = shift_r;
    len_nxt      = len_r;
    pay_end_nxt  = pay_end_r;
    scrc_nxt     = scrc_r;
    crc_nxt      = crc_r;
    err_code_nxt = err_code_r;
    err_off_nxt  = err_off_r;
    err_exp_nxt  = err_exp_r;
    err_act_nxt  = err_act_r;

    // Take the byte: header field, payload CRC or trailing data.
    if (take) begin
      if (pos_r < HDR_BYTES) begin
        shift_nxt = {in_data.data_byte, shift_r[31:8]};
        pos_nxt   = pos_r + 33'd1;
        if (pos_r[1:0] == 2'b11) begin
          unique case (pos_r[4:2])
            FLD_MAGIC: begin
              if (shift_nxt != magic_r) begin
                err_code_nxt = ST_MAGIC;
                err_off_nxt  = 33'd0;
                pos_nxt      = pos_r;
              end
            end
            FLD_VERSION: begin
              if (shift_nxt != version_r) begin
                err_code_nxt = ST_VERSION;
                err_off_nxt  = OFF_VERSION;
                err_exp_nxt  = version_r;
                err_act_nxt  = shift_nxt;
                pos_nxt      = pos_r;
              end
            end
            FLD_ALGO: begin
              if (shift_nxt != algo_r) begin
                err_code_nxt = ST_ALGO;
                err_off_nxt  = OFF_ALGO;
                err_exp_nxt  = algo_r;
                err_act_nxt  = shift_nxt;
                pos_nxt      = pos_r;
              end
            end
            FLD_LENGTH: begin
              len_nxt     = shift_nxt;
              pay_end_nxt = HDR_BYTES + {1'b0, shift_nxt};
            end
            FLD_CRC: begin
              scrc_nxt = shift_nxt;
            end
            default: ;
          endcase
        end
      end else if (pos_r < pay_end_r) begin
        crc_nxt = crc32_byte(crc_r, in_data.data_byte);
        pos_nxt = pos_r + 33'd1;
      end else begin
        err_code_nxt = ST_TRAIL;
        err_off_nxt  = pay_end_r;
      end
    end

    // Verdict at end of file, built on the state after this byte.
    crc_final = ~crc_nxt;
    res.status         = err_code_nxt;
    res.error_offset   = err_off_nxt;
    res.expected_value = err_exp_nxt;
    res.actual_value   = err_act_nxt;
    res.payload_length = len_nxt;
    if (err_code_nxt == ST_OK) begin
      if (pos_nxt < HDR_BYTES) begin
        res.status       = ST_TRUNC;
        res.error_offset = {pos_nxt[32:2], 2'b00};
      end else if (pos_nxt < pay_end_nxt) begin
        res.status       = ST_SHORT;
        res.error_offset = HDR_BYTES;
      end else if (crc_final != scrc_nxt) begin
        res.status         = ST_CRC;
        res.error_offset   = OFF_CRC_FIELD;
        res.expected_value = scrc_nxt;
        res.actual_value   = crc_final;
      end
    end

    // The end transaction returns the file state to its reset values.
    if (eof_acc) begin
      pos_nxt      = 33'd0;
      shift_nxt    = 32'd0;
      len_nxt      = 32'd0;
      pay_end_nxt  = HDR_BYTES;
      scrc_nxt     = 32'd0;
      crc_nxt      = CRC_INIT;
      err_code_nxt = ST_OK;
      err_off_nxt  = 33'd0;
      err_exp_nxt  = 32'd0;
      err_act_nxt  = 32'd0;
    end
  end

  // File state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 33'd0;
      shift_r    <= 32'd0;
      len_r      <= 32'd0;
      pay_end_r  <= HDR_BYTES;
      scrc_r     <= 32'd0;
      crc_r      <= CRC_INIT;
      err_code_r <= ST_OK;
      err_off_r  <= 33'd0;
      err_exp_r  <= 32'd0;
      err_act_r  <= 32'd0;
    end else begin
      pos_r      <= pos_nxt;
      shift_r    <= shift_nxt;
      len_r      <= len_nxt;
      pay_end_r  <= pay_end_nxt;
      scrc_r     <= scrc_nxt;
      crc_r      <= crc_nxt;
      err_code_r <= err_code_nxt;
      err_off_r  <= err_off_nxt;
      err_exp_r  <= err_exp_nxt;
      err_act_r  <= err_act_nxt;
    end
  end

  // Input waits only while a finished result is held by the receiver.
  assign in_stall = out_valid & out_stall;

  cfe_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (eof_acc),
    .load_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An end transaction yields a result in the next cycle.
  `CFE_ASSERT_NEXT(a_eof_gives_result, clk, rst_n, eof_acc, out_valid)
  // An end transaction restarts the file state.
  `CFE_ASSERT_NEXT(a_eof_clears_state, clk, rst_n, eof_acc,
                   (pos_r == 33'd0) && (err_code_r == ST_OK) && (crc_r == CRC_INIT))
  // After an error the position is frozen until the end of the file.
  `CFE_ASSERT_NEXT(a_err_freezes_pos, clk, rst_n, (err_code_r != ST_OK) && !eof_acc,
                   $stable(pos_r))
  // A clean result reports no offset and no values.
  `CFE_ASSERT_NOW(a_ok_no_detail, clk, rst_n, out_valid && (out_data.status == ST_OK),
                  (out_data.error_offset == 33'd0) && (out_data.expected_value == 32'd0)
                  && (out_data.actual_value == 32'd0))
  // The position never runs past the end of the payload.
  `CFE_ASSERT_NOW(a_pos_bounded, clk, rst_n, pos_r >= HDR_BYTES, pos_r <= pay_end_r)

endmodule

`default_nettype wire

### tb/sv/envelope_result_checker.sv
// Scoreboard for the framed CRC-32 envelope checker: it follows the config
// port and both channels, predicts each end-of-file verdict and compares it.
// Depends on cfe_pkg for the channel types, status codes and header offsets.
`timescale 1ns / 1ps

module envelope_result_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  cfe_pkg::cfe_in_t                     in_data,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  cfe_pkg::cfe_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [cfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_wdata,
  output int                                   fail_count,
  output int                                   outstanding
);
  import cfe_pkg::*;

  // Shadow copy of the configuration registers.
  logic [31:0] magic_cfg;
  logic [31:0] version_cfg;
  logic [31:0] algo_cfg;

  // Per-file parsing state.
  logic [32:0] byte_pos;
  logic [31:0] hdr_shift;
  logic [31:0] len_word;
  logic [31:0] crc_word;
  logic [31:0] payload_crc;
  logic [2:0]  err_code;
  logic [32:0] err_off;
  logic [31:0] err_exp;
  logic [31:0] err_act;

  // Verdicts predicted but not yet seen on the result channel.
  cfe_out_t verdict_q[$];
  int       mismatches;

  assign fail_count = mismatches;

  // Bit-serial form of the reflected CRC-32, least significant data bit first.
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc,
                                                 input logic [7:0]  b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic int field_differs(input string label, input logic [32:0] want,
                                       input logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_file();
    byte_pos    = '0;
    hdr_shift   = '0;
    len_word    = '0;
    crc_word    = '0;
    payload_crc = CRC_INIT;
    err_code    = ST_OK;
    err_off     = '0;
    err_exp     = '0;
    err_act     = '0;
  endtask

  // Only the first error of a file is kept.
  task automatic note_error(input logic [2:0] code, input logic [32:0] off,
                            input logic [31:0] exp_v, input logic [31:0] act_v);
    if (err_code == ST_OK) begin
      err_code = code;
      err_off  = off;
      err_exp  = exp_v;
      err_act  = act_v;
    end
  endtask

  // One file byte: header words are checked as they complete, payload bytes
  // feed the CRC, and a byte beyond the declared length is a trailing error.
  task automatic absorb_byte(input logic [7:0] b);
    logic [32:0] limit;
    logic [31:0] word;
    limit = HDR_BYTES + {1'b0, len_word};
    if (byte_pos < HDR_BYTES) begin
      word      = {b, hdr_shift[31:8]};
      hdr_shift = word;
      if (byte_pos[1:0] == 2'd3) begin
        case (byte_pos[4:2])
          FLD_MAGIC: begin
            if (word != magic_cfg) begin
              note_error(ST_MAGIC, '0, '0, '0);
              return;
            end
          end
          FLD_VERSION: begin
            if (word != version_cfg) begin
              note_error(ST_VERSION, OFF_VERSION, version_cfg, word);
              return;
            end
          end
          FLD_ALGO: begin
            if (word != algo_cfg) begin
              note_error(ST_ALGO, OFF_ALGO, algo_cfg, word);
              return;
            end
          end
          FLD_LENGTH: len_word = word;
          default: crc_word = word;
        endcase
      end
      byte_pos = byte_pos + 33'd1;
    end else if (byte_pos < limit) begin
      payload_crc = crc_shift_byte(payload_crc, b);
      byte_pos    = byte_pos + 33'd1;
    end else begin
      note_error(ST_TRAIL, limit, '0, '0);
    end
  endtask

  // End of file: settle truncation, short payload or CRC, then queue the verdict.
  task automatic conclude_file();
    logic [32:0] limit;
    cfe_out_t    res;
    limit = HDR_BYTES + {1'b0, len_word};
    if (err_code == ST_OK) begin
      if (byte_pos < HDR_BYTES) begin
        note_error(ST_TRUNC, {byte_pos[32:2], 2'b00}, '0, '0);
      end else if (byte_pos < limit) begin
        note_error(ST_SHORT, HDR_BYTES, '0, '0);
      end else if (~payload_crc != crc_word) begin
        note_error(ST_CRC, OFF_CRC_FIELD, crc_word, ~payload_crc);
      end
    end
    res.status         = err_code;
    res.error_offset   = err_off;
    res.expected_value = err_exp;
    res.actual_value   = err_act;
    res.payload_length = len_word;
    verdict_q = {verdict_q, res};
    clear_file();
  endtask

  // Follow every transaction on both channels and every register write.
  always @(posedge clk) begin : watch
    cfe_out_t want;
    if (!rst_n) begin
      magic_cfg   = MAGIC_RESET;
      version_cfg = VERSION_RESET;
      algo_cfg    = ALGO_RESET;
      clear_file();
      verdict_q.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:   magic_cfg   = cfg_wdata;
          CFG_VERSION: version_cfg = cfg_wdata;
          CFG_ALGO:    algo_cfg    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.has_byte && err_code == ST_OK) absorb_byte(in_data.data_byte);
        if (in_data.end_of_file) conclude_file();
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          mismatches += field_differs("status", {30'd0, want.status},
                                      {30'd0, out_data.status});
          mismatches += field_differs("error_offset", want.error_offset,
                                      out_data.error_offset);
          mismatches += field_differs("expected_value", {1'b0, want.expected_value},
                                      {1'b0, out_data.expected_value});
          mismatches += field_differs("actual_value", {1'b0, want.actual_value},
                                      {1'b0, out_data.actual_value});
          mismatches += field_differs("payload_length", {1'b0, want.payload_length},
                                      {1'b0, out_data.payload_length});
        end
      end
      outstanding <= verdict_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// Top of the envelope checker testbench: clock, reset, file stimulus, config
// phases and the verdict. Depends on cfe_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb;
  import cfe_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {
    FK_GOOD, FK_TRUNC, FK_MAGIC, FK_VERSION, FK_ALGO, FK_SHORT, FK_TRAIL, FK_CRC,
    FK_NOISE
  } file_kind_e;

  // No register sits behind this index; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  cfe_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  cfe_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_wdata;
  int                    fail_count;
  int                    outstanding;

  // Register values the generated headers are built against.
  logic [31:0] cur_magic   = MAGIC_RESET;
  logic [31:0] cur_version = VERSION_RESET;
  logic [31:0] cur_algo    = ALGO_RESET;
  bit          no_idle     = 1'b0;
  int          items_sent  = 0;

  crc32_framed_envelope_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  envelope_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the result channel hangs.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side back-pressure, off during the no-idle phase.
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 33);
    end
  end

  // Encoder-side CRC used to build files with a correct stored checksum.
  function automatic logic [31:0] file_crc(input byte_q_t pay);
    logic [31:0] crc;
    crc = CRC_INIT;
    foreach (pay[i]) begin
      crc = crc ^ {24'd0, pay[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return ~crc;
  endfunction

  function automatic logic [31:0] flip_mask();
    return $urandom_range(1) ? (32'd1 << $urandom_range(31)) : ($urandom | 32'd1);
  endfunction

  // One transaction on the input channel, then an optional idle gap.
  task automatic push_item(input logic [7:0] b, input bit has, input bit eof);
    cfe_in_t it;
    int      gap;
    it.data_byte   = b;
    it.has_byte    = has;
    it.end_of_file = eof;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (has || eof) items_sent++;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 33) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every verdict is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_config(input logic [31:0] m, input logic [31:0] v,
                                input logic [31:0] a);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_index <= CFG_ALGO;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_magic   = m;
    cur_version = v;
    cur_algo    = a;
  endtask

  // Build one file of the given kind and send it, with stray empty items and
  // the end flag either on the last byte or on a bare marker.
  task automatic run_file(input file_kind_e kind, input int plen, input int cut);
    byte_q_t      pay;
    byte_q_t      f;
    logic [31:0]  magic;
    logic [31:0]  ver;
    logic [31:0]  alg;
    logic [31:0]  len;
    logic [31:0]  crc;
    logic [159:0] hdr;
    bit           bare;
    magic = cur_magic;
    ver   = cur_version;
    alg   = cur_algo;
    for (int i = 0; i < plen; i++) begin
      case ($urandom_range(9))
        0:       pay = {pay, 8'h00};
        1:       pay = {pay, 8'hFF};
        default: pay = {pay, 8'($urandom_range(255))};
      endcase
    end
    len = plen;
    crc = file_crc(pay);
    case (kind)
      FK_MAGIC:   magic = magic ^ flip_mask();
      FK_VERSION: ver   = ver ^ flip_mask();
      FK_ALGO:    alg   = alg ^ flip_mask();
      FK_CRC:     crc   = crc ^ flip_mask();
      FK_SHORT: begin
        if ($urandom_range(3) == 0) len = $urandom;
        if (len <= plen) len = plen + 1 + $urandom_range(7);
      end
      default: ;
    endcase
    hdr = {crc, len, alg, ver, magic};
    for (int k = 0; k < 20; k++) f = {f, hdr[8*k +: 8]};
    foreach (pay[i]) f = {f, pay[i]};
    if (kind == FK_TRAIL) begin
      repeat ($urandom_range(1, 4)) f = {f, 8'($urandom_range(255))};
    end
    if (kind == FK_TRUNC) begin
      while (f.size() > cut) void'(f.pop_back());
    end
    if (kind == FK_NOISE) begin
      f.delete();
      repeat ($urandom_range(30)) f = {f, 8'($urandom_range(255))};
    end
    bare = (f.size() == 0) || $urandom_range(1);
    foreach (f[i]) begin
      if ($urandom_range(99) < 8) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(f[i], 1'b1, !bare && (i == f.size() - 1));
    end
    if (bare) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    file_kind_e  kind;
    int          plen;
    int          target;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files: every status, empty file, ends inside the magic and the
    // CRC word, an empty payload and a lone item that carries nothing.
    push_item(8'hFF, 1'b0, 1'b0);
    run_file(FK_TRUNC, 0, 0);
    run_file(FK_GOOD, 0, 0);
    run_file(FK_GOOD, 3, 0);
    run_file(FK_TRUNC, 4, 3);
    run_file(FK_TRUNC, 4, 17);
    run_file(FK_MAGIC, 2, 0);
    run_file(FK_TRUNC, 0, 4);
    run_file(FK_VERSION, 1, 0);
    run_file(FK_ALGO, 1, 0);
    run_file(FK_SHORT, 2, 0);
    run_file(FK_TRAIL, 1, 0);
    run_file(FK_CRC, 2, 0);
    drain();

    // Random files over several register settings, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: program_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        2: program_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: program_config($urandom, $urandom, $urandom);
        4: program_config(MAGIC_RESET, VERSION_RESET, ALGO_RESET);
        default: ;
      endcase
      no_idle = (phase == 2);
      target  = items_sent + 110;
      while (items_sent < target) begin
        if ($urandom_range(19) == 0) drain();
        kind = $urandom_range(1) ? FK_GOOD : file_kind_e'($urandom_range(FK_TRUNC, FK_NOISE));
        plen = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(12);
        run_file(kind, plen, $urandom_range(19));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### crc32_framed_envelope_check.f
+incdir+rtl/core
rtl/core/cfe_pkg.sv
rtl/core/cfe_out_stage.sv
rtl/core/crc32_framed_envelope_check.sv
tb/sv/envelope_result_checker.sv
tb/sv/tb.sv
